// File: sv/rcc_pkg.sv
// Shared types and constants for the refrigerator compressor controller.
// Used by rcc_core, rcc_out_buf and the top level; depends on nothing.
`timescale 1ns / 1ps

package rcc_pkg;

  typedef enum logic [1:0] {
    MODE_OFF   = 2'd0,
    MODE_ON    = 2'd1,
    MODE_DELAY = 2'd2
  } rcc_mode_e;

  // Configuration register indexes.
  localparam logic [1:0] CFG_ON_TEMP     = 2'd0;
  localparam logic [1:0] CFG_START_DELAY = 2'd1;
  localparam logic [1:0] CFG_SLEEP       = 2'd2;
  localparam logic [1:0] CFG_SC_HOURS    = 2'd3;

  localparam int unsigned CFG_DATA_W = 16;

  // Configuration reset values.
  localparam logic signed [7:0] ON_TEMP_RESET     = 8'sd4;
  localparam logic [15:0]       START_DELAY_RESET = 16'd20;
  localparam logic [15:0]       SLEEP_RESET       = 16'd120;
  localparam logic [7:0]        SC_HOURS_RESET    = 8'd8;

  localparam logic [5:0] MINUTE_RELOAD  = 6'd60;
  localparam logic [5:0] RUN_MIN_RELOAD = 6'd60;
  localparam logic [7:0] RUN_HOURS_MAX  = 8'd255;
  localparam logic [2:0] LEVEL_RESET    = 3'd3;
  localparam logic [2:0] LEVEL_MIN      = 3'd1;
  localparam logic [2:0] LEVEL_MAX      = 3'd5;
  localparam logic [1:0] HOLD_FULL      = 2'd3;

  // Off temperature is OFF_TEMP_BASE minus two degrees per level above one.
  localparam logic signed [7:0] OFF_TEMP_BASE = -8'sd16;

  // Indicator patterns, active low.
  localparam logic [7:0] PATTERN_SC       = 8'b0000_0101;
  localparam logic [7:0] PATTERN_SC_LOCK  = 8'b0000_0110;
  localparam logic [7:0] PATTERN_LOCK_ON  = 8'b1111_1110;
  localparam logic [7:0] PATTERN_LOCK_OFF = 8'b1111_1011;

  typedef struct packed {
    logic              operation;
    logic signed [7:0] temperature;
    logic              level_key_press;
    logic              super_key_press;
    logic              lock_key_press;
    logic              lock_key_level;
  } rcc_item_t;

  typedef struct packed {
    rcc_mode_e   compressor_mode;
    logic        compressor_drive;
    logic [2:0]  level_setting;
    logic        supercool_active;
    logic        lock_active;
    logic        display_awake;
    logic [7:0]  indicator_pattern;
  } rcc_result_t;

endpackage

// File: sv/rcc_core.sv
// Controller state, configuration registers and the single-pass update logic.
// Depends on rcc_pkg; produces the result of the beat being accepted.
`timescale 1ns / 1ps

module rcc_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [1:0]                         cfg_index_i,
  input  logic [rcc_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                               step_i,
  input  rcc_pkg::rcc_item_t                 item_i,
  output rcc_pkg::rcc_result_t               result_o
);

  logic signed [7:0] on_temp_q;
  logic [15:0]       start_delay_q;
  logic [15:0]       sleep_sec_q;
  logic [7:0]        sc_hours_q;

  rcc_pkg::rcc_mode_e mode_q, mode_d;
  logic [15:0]        delay_q, delay_d;
  logic [15:0]        sleep_q, sleep_d;
  logic [5:0]         minute_q, minute_d;
  logic [5:0]         run_min_q, run_min_d;
  logic [7:0]         run_hours_q, run_hours_d;
  logic [2:0]         level_q, level_d;
  logic               sc_q, sc_d;
  logic               lock_q, lock_d;
  logic [1:0]         hold_q, hold_d;
  logic signed [7:0]  off_temp_q, off_temp_d;
  logic [7:0]         pattern_q, pattern_d;

  logic [2:0]         level_inc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      on_temp_q     <= rcc_pkg::ON_TEMP_RESET;
      start_delay_q <= rcc_pkg::START_DELAY_RESET;
      sleep_sec_q   <= rcc_pkg::SLEEP_RESET;
      sc_hours_q    <= rcc_pkg::SC_HOURS_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        rcc_pkg::CFG_ON_TEMP:     on_temp_q     <= $signed(cfg_data_i[7:0]);
        rcc_pkg::CFG_START_DELAY: start_delay_q <= cfg_data_i[15:0];
        rcc_pkg::CFG_SLEEP:       sleep_sec_q   <= cfg_data_i[15:0];
        rcc_pkg::CFG_SC_HOURS:    sc_hours_q    <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  assign level_inc = level_q + 3'd1;

  always_comb begin
    mode_d      = mode_q;
    delay_d     = delay_q;
    sleep_d     = sleep_q;
    minute_d    = minute_q;
    run_min_d   = run_min_q;
    run_hours_d = run_hours_q;
    level_d     = level_q;
    sc_d        = sc_q;
    lock_d      = lock_q;
    hold_d      = hold_q;
    off_temp_d  = off_temp_q;
    pattern_d   = pattern_q;

    if (item_i.operation) begin
      // Minute rollover and supercool run time.
      if (minute_q == 6'd0) begin
        if (sc_q) begin
          run_min_d = run_min_q - 6'd1;
          if (run_min_d == 6'd0) begin
            if (run_hours_q != rcc_pkg::RUN_HOURS_MAX) begin
              run_hours_d = run_hours_q + 8'd1;
            end
            run_min_d = rcc_pkg::RUN_MIN_RELOAD;
          end
        end
        minute_d = rcc_pkg::MINUTE_RELOAD;
      end

      // Compressor mode machine.
      if (sc_q) begin
        if (mode_q == rcc_pkg::MODE_OFF) begin
          mode_d  = rcc_pkg::MODE_DELAY;
          delay_d = start_delay_q;
        end else if (mode_q == rcc_pkg::MODE_DELAY && delay_q == 16'd0) begin
          mode_d = rcc_pkg::MODE_ON;
        end else if (run_hours_d > sc_hours_q) begin
          mode_d      = rcc_pkg::MODE_OFF;
          sc_d        = 1'b0;
          run_min_d   = rcc_pkg::RUN_MIN_RELOAD;
          run_hours_d = 8'd0;
        end
      end else begin
        if (item_i.temperature >= on_temp_q && mode_q == rcc_pkg::MODE_OFF) begin
          mode_d  = rcc_pkg::MODE_DELAY;
          delay_d = start_delay_q;
        end else if (mode_q == rcc_pkg::MODE_DELAY && delay_q == 16'd0) begin
          mode_d = rcc_pkg::MODE_ON;
        end else if (item_i.temperature <= off_temp_q) begin
          mode_d = rcc_pkg::MODE_OFF;
        end
      end

      // Keys in priority order: level, supercool, lock.
      if (item_i.level_key_press) begin
        if (sleep_q == 16'd0) begin
          sleep_d = sleep_sec_q;
        end else if (!sc_d && !lock_q) begin
          level_d = (level_inc > rcc_pkg::LEVEL_MAX) ? rcc_pkg::LEVEL_MIN : level_inc;
        end else if (sc_d && !lock_q) begin
          sc_d        = 1'b0;
          run_min_d   = rcc_pkg::RUN_MIN_RELOAD;
          run_hours_d = 8'd0;
        end
      end else if (item_i.super_key_press) begin
        if (sleep_q == 16'd0) begin
          sleep_d = sleep_sec_q;
        end else if (!lock_q) begin
          sc_d        = 1'b1;
          run_min_d   = rcc_pkg::RUN_MIN_RELOAD;
          run_hours_d = 8'd0;
        end
      end else if (item_i.lock_key_press) begin
        if (sleep_q == 16'd0) begin
          sleep_d = sleep_sec_q;
        end
        if (hold_q == rcc_pkg::HOLD_FULL) begin
          hold_d = 2'd0;
          lock_d = ~lock_q;
        end
      end

      // Indicator refresh.
      if (sc_d) begin
        pattern_d = lock_d ? rcc_pkg::PATTERN_SC_LOCK : rcc_pkg::PATTERN_SC;
      end else if (level_d >= rcc_pkg::LEVEL_MIN && level_d <= rcc_pkg::LEVEL_MAX) begin
        off_temp_d = rcc_pkg::OFF_TEMP_BASE - $signed({1'b0, 3'(level_d - 3'd1), 1'b0});
        pattern_d  = (lock_d ? rcc_pkg::PATTERN_LOCK_ON : rcc_pkg::PATTERN_LOCK_OFF)
                     & ~(8'd1 << (level_d + 3'd2));
      end
    end else begin
      if (item_i.lock_key_level && hold_q != rcc_pkg::HOLD_FULL) begin
        hold_d = hold_q + 2'd1;
      end else if (!item_i.lock_key_level) begin
        hold_d = 2'd0;
      end
      if (sleep_q != 16'd0) sleep_d = sleep_q - 16'd1;
      if (delay_q != 16'd0) delay_d = delay_q - 16'd1;
      if (minute_q != 6'd0 && mode_q != rcc_pkg::MODE_OFF) begin
        minute_d = minute_q - 6'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= rcc_pkg::MODE_OFF;
      delay_q     <= rcc_pkg::START_DELAY_RESET;
      sleep_q     <= rcc_pkg::SLEEP_RESET;
      minute_q    <= 6'd0;
      run_min_q   <= rcc_pkg::RUN_MIN_RELOAD;
      run_hours_q <= 8'd0;
      level_q     <= rcc_pkg::LEVEL_RESET;
      sc_q        <= 1'b0;
      lock_q      <= 1'b0;
      hold_q      <= 2'd0;
      off_temp_q  <= 8'sd0;
      pattern_q   <= 8'd0;
    end else if (step_i) begin
      mode_q      <= mode_d;
      delay_q     <= delay_d;
      sleep_q     <= sleep_d;
      minute_q    <= minute_d;
      run_min_q   <= run_min_d;
      run_hours_q <= run_hours_d;
      level_q     <= level_d;
      sc_q        <= sc_d;
      lock_q      <= lock_d;
      hold_q      <= hold_d;
      off_temp_q  <= off_temp_d;
      pattern_q   <= pattern_d;
    end
  end

  always_comb begin
    result_o.compressor_mode   = mode_d;
    result_o.compressor_drive  = (mode_d == rcc_pkg::MODE_ON);
    result_o.level_setting     = level_d;
    result_o.supercool_active  = sc_d;
    result_o.lock_active       = lock_d;
    result_o.display_awake     = (sleep_d != 16'd0);
    result_o.indicator_pattern = pattern_d;
  end

endmodule

// File: sv/rcc_out_buf.sv
// Two-entry result buffer: an output register plus a skid slot.
// Depends on rcc_pkg for the result type.
`timescale 1ns / 1ps

module rcc_out_buf (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  rcc_pkg::rcc_result_t push_data_i,
  output logic                 full_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output rcc_pkg::rcc_result_t out_data_o
);

  rcc_pkg::rcc_result_t head_q, head_d;
  rcc_pkg::rcc_result_t skid_q, skid_d;
  logic                 head_vld_q, head_vld_d;
  logic                 skid_vld_q, skid_vld_d;
  logic                 pop;

  assign pop = head_vld_q && !out_stall_i;

  always_comb begin
    head_d     = head_q;
    skid_d     = skid_q;
    head_vld_d = head_vld_q;
    skid_vld_d = skid_vld_q;
    if (!head_vld_q) begin
      head_d     = push_data_i;
      head_vld_d = push_i;
    end else if (pop) begin
      if (skid_vld_q) begin
        head_d     = skid_q;
        skid_d     = push_data_i;
        skid_vld_d = push_i;
      end else begin
        head_d     = push_data_i;
        head_vld_d = push_i;
      end
    end else if (push_i) begin
      // Pushes only arrive while the skid slot is empty.
      skid_d     = push_data_i;
      skid_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_vld_q <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      head_vld_q <= head_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    head_q <= head_d;
    skid_q <= skid_d;
  end

  assign full_o      = skid_vld_q;
  assign out_valid_o = head_vld_q;
  assign out_data_o  = head_q;

endmodule

// File: sv/refrigerator_compressor_controller.sv
// Refrigerator compressor controller. Throughput: one beat per cycle while
// in_stall_o is low, set by the single registered state update; each result is
// registered in a two-entry result buffer, whose skid slot keeps input accepted
// while one result waits. Reset (rst_ni low, asynchronous) restores state and
// configuration registers to their defaults and empties the result buffer.
`timescale 1ns / 1ps

module refrigerator_compressor_controller (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [1:0]                     cfg_index_i,
  input  logic [rcc_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           operation_i,
  input  logic signed [7:0]              temperature_i,
  input  logic                           level_key_press_i,
  input  logic                           super_key_press_i,
  input  logic                           lock_key_press_i,
  input  logic                           lock_key_level_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [1:0]                     compressor_mode_o,
  output logic                           compressor_drive_o,
  output logic [2:0]                     level_setting_o,
  output logic                           supercool_active_o,
  output logic                           lock_active_o,
  output logic                           display_awake_o,
  output logic [7:0]                     indicator_pattern_o
);

  rcc_pkg::rcc_item_t   item;
  rcc_pkg::rcc_result_t next_result;
  rcc_pkg::rcc_result_t out_result;
  logic                 step;
  logic                 buf_full;

  assign item.operation       = operation_i;
  assign item.temperature     = temperature_i;
  assign item.level_key_press = level_key_press_i;
  assign item.super_key_press = super_key_press_i;
  assign item.lock_key_press  = lock_key_press_i;
  assign item.lock_key_level  = lock_key_level_i;

  assign in_stall_o = buf_full;
  assign step       = in_valid_i && !buf_full;

  rcc_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .step_i      (step),
    .item_i      (item),
    .result_o    (next_result)
  );

  rcc_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (step),
    .push_data_i (next_result),
    .full_o      (buf_full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_result)
  );

  assign compressor_mode_o   = out_result.compressor_mode;
  assign compressor_drive_o  = out_result.compressor_drive;
  assign level_setting_o     = out_result.level_setting;
  assign supercool_active_o  = out_result.supercool_active;
  assign lock_active_o       = out_result.lock_active;
  assign display_awake_o     = out_result.display_awake;
  assign indicator_pattern_o = out_result.indicator_pattern;

endmodule

// File: sv/rcc_checker.sv
// Port-level assertions for the compressor controller, bound to the top level.
// Depends only on the top-level ports.
`timescale 1ns / 1ps

module rcc_checker (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     in_stall_o,
  input logic                     out_valid_o,
  input logic                     out_stall_i,
  input logic [1:0]               compressor_mode_o,
  input logic                     compressor_drive_o,
  input logic [2:0]               level_setting_o,
  input logic [7:0]               indicator_pattern_o
);

  // The buffer can only be full when its head holds a beat.
  a_stall_needs_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with no result waiting");

  a_drive_matches_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (compressor_drive_o == (compressor_mode_o == 2'd1)))
    else $error("compressor drive disagrees with mode");

  a_level_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (level_setting_o == 3'd1 || level_setting_o == 3'd2 ||
                     level_setting_o == 3'd3 || level_setting_o == 3'd4 ||
                     level_setting_o == 3'd5))
    else $error("level outside one to five");

  a_stalled_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(compressor_mode_o) &&
                                   $stable(level_setting_o) &&
                                   $stable(indicator_pattern_o))
    else $error("stalled result changed");

endmodule

bind refrigerator_compressor_controller rcc_checker u_rcc_checker (.*);

// File: test/tb_refrigerator_compressor_controller.sv
// Self-checking testbench for refrigerator_compressor_controller: a queue-fed driver,
// a monitor and an in-bench model of the controller state checked on every result beat.
// Depends on rcc_pkg for the item, result, mode and register index definitions.
`timescale 1ns / 1ps

module tb_refrigerator_compressor_controller;

  localparam logic OP_TICK = 1'b0;
  localparam logic OP_EVAL = 1'b1;

  // Length of the closing supercool run in run minutes.
  localparam int RUN_MINUTES = 3;

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_we = 1'b0;
  logic [1:0]        cfg_index = rcc_pkg::CFG_ON_TEMP;
  logic [15:0]       cfg_data = '0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic              operation = OP_TICK;
  logic signed [7:0] temperature = '0;
  logic              level_key = 1'b0;
  logic              super_key = 1'b0;
  logic              lock_key = 1'b0;
  logic              lock_level = 1'b0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [1:0]        compressor_mode;
  logic              compressor_drive;
  logic [2:0]        level_setting;
  logic              supercool_active;
  logic              lock_active;
  logic              display_awake;
  logic [7:0]        indicator_pattern;

  refrigerator_compressor_controller u_dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we),
    .cfg_index_i         (cfg_index),
    .cfg_data_i          (cfg_data),
    .in_valid_i          (in_valid),
    .in_stall_o          (in_stall),
    .operation_i         (operation),
    .temperature_i       (temperature),
    .level_key_press_i   (level_key),
    .super_key_press_i   (super_key),
    .lock_key_press_i    (lock_key),
    .lock_key_level_i    (lock_level),
    .out_valid_o         (out_valid),
    .out_stall_i         (out_stall),
    .compressor_mode_o   (compressor_mode),
    .compressor_drive_o  (compressor_drive),
    .level_setting_o     (level_setting),
    .supercool_active_o  (supercool_active),
    .lock_active_o       (lock_active),
    .display_awake_o     (display_awake),
    .indicator_pattern_o (indicator_pattern)
  );

  // Configuration as the controller should currently see it.
  logic signed [7:0] cfg_on_temp;
  logic [15:0]       cfg_start_delay;
  logic [15:0]       cfg_sleep;
  logic [7:0]        cfg_sc_hours;

  // Controller state tracked by the predictor.
  rcc_pkg::rcc_mode_e st_mode;
  logic [15:0]        st_delay;
  logic [15:0]        st_sleep;
  logic [5:0]         st_minute;
  logic [5:0]         st_run_min;
  logic [7:0]         st_run_hours;
  logic [2:0]         st_level;
  logic               st_sc;
  logic               st_lock;
  logic [1:0]         st_hold;
  logic signed [7:0]  st_off_temp;
  logic [7:0]         st_pattern;

  rcc_pkg::rcc_item_t   pending_items[$];
  rcc_pkg::rcc_result_t expected_status_q[$];
  rcc_pkg::rcc_item_t   cur_item;
  rcc_pkg::rcc_result_t got;
  rcc_pkg::rcc_result_t want;

  int  items_sent = 0;
  int  results_seen = 0;
  int  err_count = 0;
  int  gap_left = 0;
  int  stall_left = 0;
  bit  in_idle_en = 1'b0;
  bit  out_idle_en = 1'b0;
  bit  key_held = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  initial begin
    #50_000_000;
    $display("refrigerator_compressor_controller regression: fail");
    $finish;
  end

  function automatic void reset_controller();
    cfg_on_temp     = rcc_pkg::ON_TEMP_RESET;
    cfg_start_delay = rcc_pkg::START_DELAY_RESET;
    cfg_sleep       = rcc_pkg::SLEEP_RESET;
    cfg_sc_hours    = rcc_pkg::SC_HOURS_RESET;
    st_mode      = rcc_pkg::MODE_OFF;
    st_delay     = rcc_pkg::START_DELAY_RESET;
    st_sleep     = rcc_pkg::SLEEP_RESET;
    st_minute    = '0;
    st_run_min   = rcc_pkg::RUN_MIN_RELOAD;
    st_run_hours = '0;
    st_level     = rcc_pkg::LEVEL_RESET;
    st_sc        = 1'b0;
    st_lock      = 1'b0;
    st_hold      = '0;
    st_off_temp  = '0;
    st_pattern   = '0;
  endfunction

  function automatic void clear_run_time();
    st_run_min   = rcc_pkg::RUN_MIN_RELOAD;
    st_run_hours = '0;
  endfunction

  // Applies one beat to the tracked state and returns the status it leaves behind.
  function automatic rcc_pkg::rcc_result_t step_controller(rcc_pkg::rcc_item_t it);
    logic                 served;
    rcc_pkg::rcc_result_t r;
    served = 1'b0;
    if (it.operation == OP_TICK) begin
      if (st_hold < rcc_pkg::HOLD_FULL && it.lock_key_level) st_hold = st_hold + 2'd1;
      else if (!it.lock_key_level) st_hold = '0;
      if (st_sleep != 0) st_sleep = st_sleep - 16'd1;
      if (st_delay != 0) st_delay = st_delay - 16'd1;
      if (st_minute != 0 && st_mode != rcc_pkg::MODE_OFF) st_minute = st_minute - 6'd1;
    end else begin
      if (st_minute == 0) begin
        if (st_sc) begin
          st_run_min = st_run_min - 6'd1;
          if (st_run_min == 0) begin
            if (st_run_hours != rcc_pkg::RUN_HOURS_MAX) st_run_hours = st_run_hours + 8'd1;
            st_run_min = rcc_pkg::RUN_MIN_RELOAD;
          end
        end
        st_minute = rcc_pkg::MINUTE_RELOAD;
      end

      if (st_sc) begin
        if (st_mode == rcc_pkg::MODE_OFF) begin
          st_mode  = rcc_pkg::MODE_DELAY;
          st_delay = cfg_start_delay;
        end else if (st_mode == rcc_pkg::MODE_DELAY && st_delay == 0) begin
          st_mode = rcc_pkg::MODE_ON;
        end else if (st_run_hours > cfg_sc_hours) begin
          st_mode = rcc_pkg::MODE_OFF;
          st_sc   = 1'b0;
          clear_run_time();
        end
      end else begin
        if (it.temperature >= cfg_on_temp && st_mode == rcc_pkg::MODE_OFF) begin
          st_mode  = rcc_pkg::MODE_DELAY;
          st_delay = cfg_start_delay;
        end else if (st_mode == rcc_pkg::MODE_DELAY && st_delay == 0) begin
          st_mode = rcc_pkg::MODE_ON;
        end else if (it.temperature <= st_off_temp) begin
          st_mode = rcc_pkg::MODE_OFF;
        end
      end

      // Level key wins over supercool, supercool over lock.
      if (it.level_key_press) begin
        served = 1'b1;
        if (st_sleep == 0) begin
          st_sleep = cfg_sleep;
        end else if (!st_sc && !st_lock) begin
          st_level = st_level + 3'd1;
          if (st_level > rcc_pkg::LEVEL_MAX) st_level = rcc_pkg::LEVEL_MIN;
        end else if (st_sc && !st_lock) begin
          st_sc = 1'b0;
          clear_run_time();
        end
      end
      if (it.super_key_press && !served) begin
        served = 1'b1;
        if (st_sleep == 0) begin
          st_sleep = cfg_sleep;
        end else if (!st_lock) begin
          st_sc = 1'b1;
          clear_run_time();
        end
      end
      if (it.lock_key_press && !served) begin
        if (st_sleep == 0) st_sleep = cfg_sleep;
        if (st_hold == rcc_pkg::HOLD_FULL) begin
          st_hold = '0;
          st_lock = ~st_lock;
        end
      end

      if (st_sc) begin
        st_pattern = st_lock ? rcc_pkg::PATTERN_SC_LOCK : rcc_pkg::PATTERN_SC;
      end else if (st_level >= rcc_pkg::LEVEL_MIN && st_level <= rcc_pkg::LEVEL_MAX) begin
        st_off_temp = 8'(int'(rcc_pkg::OFF_TEMP_BASE) - 2 * (int'(st_level) - 1));
        st_pattern  = (st_lock ? rcc_pkg::PATTERN_LOCK_ON : rcc_pkg::PATTERN_LOCK_OFF)
                      & ~(8'd1 << (st_level + 3'd2));
      end
    end

    r.compressor_mode   = st_mode;
    r.compressor_drive  = (st_mode == rcc_pkg::MODE_ON);
    r.level_setting     = st_level;
    r.supercool_active  = st_sc;
    r.lock_active       = st_lock;
    r.display_awake     = (st_sleep != 0);
    r.indicator_pattern = st_pattern;
    return r;
  endfunction

  // Input driver: one beat per free slot unless an idle burst is running.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) expected_status_q.push_back(step_controller(cur_item));
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (in_idle_en && $urandom_range(0, 9) == 0) begin
          gap_left = $urandom_range(0, 12);
          in_valid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          cur_item = pending_items.pop_front();
          in_valid    <= 1'b1;
          operation   <= cur_item.operation;
          temperature <= cur_item.temperature;
          level_key   <= cur_item.level_key_press;
          super_key   <= cur_item.super_key_press;
          lock_key    <= cur_item.lock_key_press;
          lock_level  <= cur_item.lock_key_level;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result side back-pressure.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (out_idle_en && $urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(0, 12);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid && !out_stall) begin
      got.compressor_mode   = rcc_pkg::rcc_mode_e'(compressor_mode);
      got.compressor_drive  = compressor_drive;
      got.level_setting     = level_setting;
      got.supercool_active  = supercool_active;
      got.lock_active       = lock_active;
      got.display_awake     = display_awake;
      got.indicator_pattern = indicator_pattern;
      if (expected_status_q.size() == 0) begin
        err_count++;
        if (err_count <= 10) $display("%0t: result beat with nothing expected", $realtime);
      end else begin
        want = expected_status_q.pop_front();
        results_seen++;
        if (got.compressor_mode !== want.compressor_mode ||
            got.compressor_drive !== want.compressor_drive ||
            got.level_setting !== want.level_setting ||
            got.supercool_active !== want.supercool_active ||
            got.lock_active !== want.lock_active ||
            got.display_awake !== want.display_awake ||
            got.indicator_pattern !== want.indicator_pattern) begin
          err_count++;
          if (err_count <= 10) begin
            $display("%0t: beat %0d mismatch mode/drive/level/sc/lock/awake/pattern",
                     $realtime, results_seen);
            $display("  expected %0d %b %0d %b %b %b %h", want.compressor_mode,
                     want.compressor_drive, want.level_setting, want.supercool_active,
                     want.lock_active, want.display_awake, want.indicator_pattern);
            $display("  actual   %0d %b %0d %b %b %b %h", got.compressor_mode,
                     got.compressor_drive, got.level_setting, got.supercool_active,
                     got.lock_active, got.display_awake, got.indicator_pattern);
          end
        end
      end
    end
  end

  function automatic rcc_pkg::rcc_item_t make_item(logic op, int temp, logic k1, logic k2,
                                                   logic k3, logic held);
    rcc_pkg::rcc_item_t it;
    it.operation       = op;
    it.temperature     = 8'(temp);
    it.level_key_press = k1;
    it.super_key_press = k2;
    it.lock_key_press  = k3;
    it.lock_key_level  = held;
    return it;
  endfunction

  // Mostly temperatures near the switching points, the lock key held in stretches.
  function automatic rcc_pkg::rcc_item_t random_item();
    rcc_pkg::rcc_item_t it;
    if ($urandom_range(0, 5) == 0) key_held = ~key_held;
    it.operation       = ($urandom_range(0, 99) < 55) ? OP_TICK : OP_EVAL;
    it.temperature     = ($urandom_range(0, 3) == 0) ? 8'($urandom)
                                                     : 8'(int'($urandom_range(0, 40)) - 30);
    it.level_key_press = ($urandom_range(0, 5) == 0);
    it.super_key_press = ($urandom_range(0, 5) == 0);
    it.lock_key_press  = ($urandom_range(0, 3) == 0);
    it.lock_key_level  = key_held;
    return it;
  endfunction

  task automatic push_item(rcc_pkg::rcc_item_t it);
    while (pending_items.size() >= 16) @(negedge clk_i);
    pending_items.push_back(it);
    items_sent++;
  endtask

  task automatic wait_idle();
    while (results_seen < items_sent) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    case (idx)
      rcc_pkg::CFG_ON_TEMP:     cfg_on_temp = val[7:0];
      rcc_pkg::CFG_START_DELAY: cfg_start_delay = val;
      rcc_pkg::CFG_SLEEP:       cfg_sleep = val;
      rcc_pkg::CFG_SC_HOURS:    cfg_sc_hours = val[7:0];
      default: ;
    endcase
  endtask

  // Upper data bits of the 8-bit registers are junk and must be dropped.
  task automatic write_all(int on_t, int delay, int sleep_s, int hours);
    write_reg(rcc_pkg::CFG_ON_TEMP, {8'($urandom), 8'(on_t)});
    write_reg(rcc_pkg::CFG_START_DELAY, 16'(delay));
    write_reg(rcc_pkg::CFG_SLEEP, 16'(sleep_s));
    write_reg(rcc_pkg::CFG_SC_HOURS, {8'($urandom), 8'(hours)});
  endtask

  // Holds the lock key for enough ticks and then presses it.
  task automatic lock_toggle_sequence();
    repeat ($urandom_range(3, 5)) push_item(make_item(OP_TICK, $urandom, 0, 0, 0, 1));
    push_item(make_item(OP_EVAL, $urandom, 0, 0, 1, 1));
  endtask

  initial begin : stimulus
    int n;
    reset_controller();
    @(posedge rst_ni);
    @(negedge clk_i);
    write_all(rcc_pkg::ON_TEMP_RESET, rcc_pkg::START_DELAY_RESET, rcc_pkg::SLEEP_RESET,
              rcc_pkg::SC_HOURS_RESET);
    in_idle_en  = 1'b1;
    out_idle_en = 1'b1;

    // Directed: temperature extremes, level wrap, key priority, lock and supercool.
    push_item(make_item(OP_EVAL, 127, 0, 0, 0, 0));
    push_item(make_item(OP_EVAL, -128, 0, 0, 0, 0));
    push_item(make_item(OP_TICK, 0, 0, 0, 0, 0));
    push_item(make_item(OP_EVAL, 0, 1, 0, 0, 0));
    push_item(make_item(OP_EVAL, 0, 1, 0, 0, 0));
    push_item(make_item(OP_EVAL, 0, 1, 0, 0, 0));
    push_item(make_item(OP_EVAL, 0, 1, 1, 1, 0));
    push_item(make_item(OP_EVAL, 0, 0, 1, 0, 0));
    repeat (3) push_item(make_item(OP_TICK, 0, 0, 0, 0, 1));
    push_item(make_item(OP_EVAL, 0, 0, 0, 1, 1));
    push_item(make_item(OP_EVAL, 0, 1, 0, 0, 0));
    push_item(make_item(OP_EVAL, 0, 0, 1, 0, 0));
    repeat (3) push_item(make_item(OP_TICK, 0, 0, 0, 0, 1));
    push_item(make_item(OP_EVAL, 0, 0, 0, 1, 1));
    push_item(make_item(OP_EVAL, 0, 1, 0, 0, 0));
    push_item(make_item(OP_TICK, 0, 0, 0, 0, 0));
    push_item(make_item(OP_EVAL, 4, 0, 0, 0, 0));
    push_item(make_item(OP_EVAL, 5, 0, 1, 1, 0));
    push_item(make_item(OP_EVAL, -128, 1, 0, 0, 0));
    push_item(make_item(OP_TICK, 127, 1, 1, 1, 1));
    wait_idle();

    // Random phases, each under its own register setting.
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: write_all(-128, 0, 3, 0);
        1: write_all(127, 65535, 65535, 255);
        2: write_all($urandom_range(0, 40) - 30, $urandom_range(0, 5),
                     $urandom_range(1, 15), $urandom_range(0, 255));
        3: write_all($urandom_range(0, 40) - 30, 2, 0, $urandom_range(0, 3));
        default: write_all($urandom_range(0, 40) - 30, $urandom_range(0, 30),
                           $urandom_range(1, 40), $urandom);
      endcase
      in_idle_en  = (phase == 0) || ($urandom_range(0, 2) != 0);
      out_idle_en = (phase == 0) || ($urandom_range(0, 2) != 0);
      n = 0;
      while (n < 300) begin
        if ($urandom_range(0, 19) == 0) begin
          lock_toggle_sequence();
          n += 5;
        end else begin
          push_item(random_item());
          n++;
        end
        // When the count reaches 150 the sender stops until the controller has answered everything.
        if (n == 150) wait_idle();
      end
      wait_idle();
    end

    // Supercool run of a few minutes without idling: run minutes count down.
    in_idle_en  = 1'b0;
    out_idle_en = 1'b0;
    write_all($urandom_range(0, 40) - 30, 0, 65535, 255);
    repeat (3) push_item(make_item(OP_TICK, $urandom, 0, 0, 0, 1));
    if (st_lock) push_item(make_item(OP_EVAL, $urandom, 0, 0, 1, 1));
    push_item(make_item(OP_EVAL, $urandom, 0, 1, 0, 0));
    push_item(make_item(OP_EVAL, $urandom, 0, 1, 0, 0));
    for (int m = 0; m < RUN_MINUTES; m++) begin
      repeat (60) push_item(make_item(OP_TICK, $urandom, 0, 0, 0, 1'($urandom_range(0, 1))));
      push_item(make_item(OP_EVAL, $urandom, 0, 0, 0, 0));
    end
    wait_idle();
    // A new hour limit above the run time keeps supercool going.
    write_reg(rcc_pkg::CFG_SC_HOURS, 16'd254);
    push_item(make_item(OP_EVAL, $urandom, 0, 0, 0, 0));
    push_item(make_item(OP_TICK, $urandom, 0, 0, 0, 0));
    wait_idle();

    repeat (5) @(negedge clk_i);
    if (expected_status_q.size() != 0) begin
      err_count++;
      $display("%0d expected results never arrived", expected_status_q.size());
    end
    if (err_count == 0) begin
      $display("refrigerator_compressor_controller regression: pass");
    end else begin
      $display("refrigerator_compressor_controller regression: fail");
    end
    $finish;
  end

endmodule
